### design/hcs_pkg.sv
// shared types and constants for the histogram contrast stretch unit
// no dependencies

package hcs_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int BINS_DEF       = 256;
    localparam int PIX_BITS       = 8;
    localparam int CFG_ADDR_BITS  = 2;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_MIN_COUNT = 2'd0;
    localparam logic KIND_HIST = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [PIX_BITS-1:0] pixel;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] mapped_pixel;
        logic                out_last;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_rd;    // issue read of sweep entry
        logic scan_eval;   // evaluate registered read for lo/hi
        logic scan_init;   // reset lo/hi trackers
        logic div_start;   // start divider for table entry
        logic tbl_write;   // write table entry from divider / bounds
        logic clr_write;   // write zero to bin at sweep index
        logic idx_inc;     // step sweep index
        logic idx_zero;    // reset sweep index
    } t_cmd;

    typedef struct packed {
        logic idx_end;     // sweep index at last bin
        logic div_done;    // divider finished
        logic need_div;    // current entry lies above lo and at or below hi, divider idle
    } t_status;

endpackage

### design/hcs_ctrl.sv
// controller for the histogram contrast stretch unit
// uses hcs_pkg; sequences frame-end scan, table build and bin clear

module hcs_ctrl
    import hcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,     // histogram last pixel accepted
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_BUILD, S_DIV, S_CLEAR
    } t_state;

    t_state r_state;
    logic   r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SCAN_RD;
                    end
                end
                // wait state so the registered read is ready before the first evaluate
                S_SCAN_RD: r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_status.idx_end) begin
                        r_state <= S_BUILD;
                        r_first <= 1'b1;
                    end
                end
                S_BUILD: begin
                    r_first <= 1'b0;
                    if (!r_first && i_status.need_div) begin
                        r_state <= S_DIV;
                    end else if (!r_first && i_status.idx_end) begin
                        r_state <= S_CLEAR;
                    end
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= i_status.idx_end ? S_CLEAR : S_BUILD;
                    end
                end
                S_CLEAR: begin
                    if (i_status.idx_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idx_zero  = 1'b1;
                o_cmd.scan_init = 1'b1;
                o_cmd.clear_rd  = i_start;
                o_cmd.idx_inc   = 1'b0;
            end
            S_SCAN_RD: begin
                o_cmd.idx_inc  = 1'b0;
                o_cmd.clear_rd = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_eval = 1'b1;
                o_cmd.clear_rd  = 1'b1;
                o_cmd.idx_inc   = !i_status.idx_end;
                o_cmd.idx_zero  = i_status.idx_end;
            end
            S_BUILD: begin
                if (!r_first) begin
                    if (i_status.need_div) begin
                        o_cmd.div_start = 1'b1;
                    end else begin
                        o_cmd.tbl_write = 1'b1;
                        o_cmd.idx_inc   = !i_status.idx_end;
                        o_cmd.idx_zero  = i_status.idx_end;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.tbl_write = 1'b1;
                    o_cmd.idx_inc   = !i_status.idx_end;
                    o_cmd.idx_zero  = i_status.idx_end;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.idx_inc   = !i_status.idx_end;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("frame end while busy");
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_status.idx_end) |=> r_state == S_IDLE)
        else $error("clear sweep did not finish");
    a_div_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !o_cmd.tbl_write)
        else $error("write and divide together");

endmodule

### design/hcs_datapath.sv
// datapath: bin memory, scan trackers, serial divider, stretch table
// uses hcs_pkg; driven by hcs_ctrl commands

module hcs_datapath
    import hcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int BINS       = BINS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [COUNT_BITS-1:0] i_min_count,
    input  logic                  i_hist_en,   // histogram pixel accepted
    input  logic [PIX_BITS-1:0]   i_hist_pix,
    input  logic                  i_map_rd,    // map pixel accepted
    input  logic [PIX_BITS-1:0]   i_map_pix,
    output logic [PIX_BITS-1:0]   o_map_data
);

    localparam int IDX_BITS = $clog2(BINS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    // numerator 510*k+d < 2^17, denominator 2*d < 2^9
    localparam int NUM_BITS = 17;
    localparam int DEN_BITS = 9;
    localparam int QUO_BITS = 5'd17;

    // bin memory: read-modify-write pipeline with forwarding
    logic [COUNT_BITS-1:0] r_bins [BINS];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [IDX_BITS-1:0]   r_rd_addr;
    logic                  r_rd_vld;
    logic [COUNT_BITS-1:0] r_wr_data;
    logic [IDX_BITS-1:0]   r_wr_addr;
    logic                  r_wr_vld;
    logic [COUNT_BITS-1:0] w_cur;
    logic [COUNT_BITS-1:0] w_inc;
    logic [IDX_BITS-1:0]   r_idx;
    logic [IDX_BITS-1:0]   w_rd_sel;
    logic                  w_rd_en;
    logic                  w_wr_en;
    logic [IDX_BITS-1:0]   w_wr_addr;
    logic [COUNT_BITS-1:0] w_wr_data;

    assign w_rd_en  = i_hist_en || i_cmd.clear_rd;
    assign w_rd_sel = i_hist_en ? i_hist_pix[IDX_BITS-1:0] :
                      (i_cmd.idx_inc ? r_idx + 1'b1 : r_idx);

    // single write port shared by the count update, the reset sweep and the clear sweep
    assign w_wr_en   = r_wr_vld || i_cmd.clr_write;
    assign w_wr_addr = i_cmd.clr_write ? r_idx : r_wr_addr;
    assign w_wr_data = i_cmd.clr_write ? '0 : r_wr_data;

    always_comb begin
        w_cur = r_rd_data;
        if (r_wr_vld && r_wr_addr == r_rd_addr) begin
            w_cur = r_wr_data;
        end
        w_inc = (w_cur == CNT_MAX) ? w_cur : w_cur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            // bypass the update that lands in memory at this same edge
            if (r_wr_vld && r_wr_addr == w_rd_sel) begin
                r_rd_data <= r_wr_data;
            end else begin
                r_rd_data <= r_bins[w_rd_sel];
            end
            r_rd_addr <= w_rd_sel;
        end
        if (w_wr_en) begin
            r_bins[w_wr_addr] <= w_wr_data;
        end
    end

    // reset clears the bins with a sweep through the write pipeline
    logic                r_init;
    logic [IDX_BITS-1:0] r_init_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_idx     <= '0;
            r_init    <= 1'b1;
            r_init_idx <= '0;
        end else begin
            r_rd_vld <= i_hist_en;
            r_wr_vld <= r_rd_vld || r_init;
            if (r_init) begin
                r_init_idx <= r_init_idx + 1'b1;
                if (&r_init_idx) begin
                    r_init <= 1'b0;
                end
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init) begin
            r_wr_addr <= r_init_idx;
            r_wr_data <= '0;
        end else begin
            r_wr_addr <= r_rd_addr;
            r_wr_data <= w_inc;
        end
    end

    // lo / hi trackers; the read runs one bin ahead of r_idx
    logic                r_found;
    logic [IDX_BITS-1:0] r_lo;
    logic [IDX_BITS-1:0] r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_init) begin
            r_found <= 1'b0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else if (i_cmd.scan_eval && w_cur > i_min_count) begin
            if (!r_found) begin
                r_lo <= r_idx;
            end
            r_found <= 1'b1;
            r_hi    <= r_idx;
        end
    end

    // table entry classification at r_idx
    logic w_between;
    logic [PIX_BITS-1:0] w_fixed;

    always_comb begin
        w_between = r_found && r_idx > r_lo && r_idx <= r_hi;
        if (!r_found || r_idx < r_lo || r_idx == r_lo) begin
            w_fixed = '0;
        end else begin
            w_fixed = '1;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_den;
    logic [4:0]          r_cnt;
    logic                r_div_busy;
    logic [NUM_BITS:0]   w_trial;
    logic [PIX_BITS-1:0] w_d;
    logic [PIX_BITS-1:0] w_k;

    assign w_d = r_hi - r_lo;
    assign w_k = r_idx - r_lo;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_cnt      <= QUO_BITS[4:0];
            r_rem      <= '0;
            r_quo      <= NUM_BITS'(w_k) * NUM_BITS'(10'd510) + NUM_BITS'(w_d);
            r_den      <= {w_d, 1'b0};
        end else if (r_div_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_trial >= {{(NUM_BITS+1-DEN_BITS){1'b0}}, r_den}) begin
                r_rem <= NUM_BITS'(w_trial - {{(NUM_BITS+1-DEN_BITS){1'b0}}, r_den});
                r_quo <= {r_quo[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[NUM_BITS-1:0];
                r_quo <= {r_quo[NUM_BITS-2:0], 1'b0};
            end
        end else if (i_cmd.tbl_write) begin
            r_div_busy <= 1'b0;
        end
    end

    // stretch table with valid bits for reset state
    logic [PIX_BITS-1:0] r_tbl [BINS];
    logic [BINS-1:0]     r_tbl_vld;
    logic [PIX_BITS-1:0] r_map_raw;
    logic                r_map_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_write) begin
            r_tbl[r_idx] <= r_div_busy ? r_quo[PIX_BITS-1:0] : w_fixed;
        end
        if (i_map_rd) begin
            r_map_raw <= r_tbl[i_map_pix[IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_map_vld <= 1'b0;
        end else begin
            if (i_cmd.tbl_write) begin
                r_tbl_vld[r_idx] <= 1'b1;
            end
            if (i_map_rd) begin
                r_map_vld <= r_tbl_vld[i_map_pix[IDX_BITS-1:0]];
            end
        end
    end

    assign o_map_data = r_map_vld ? r_map_raw : '0;

    assign o_status.idx_end  = &r_idx;
    assign o_status.div_done = r_div_busy && r_cnt == '0;
    assign o_status.need_div = w_between && !r_div_busy;

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> w_d != '0)
        else $error("divide by zero");
    a_no_hist_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_eval |-> !i_hist_en)
        else $error("pixel counted during scan");
    a_lo_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_lo <= r_hi)
        else $error("bounds out of order");

endmodule

### design/histogram_contrast_stretch_unit.sv
// Contrast stretch of 8-bit gray frames. A histogram pixel (kind 0) can follow another
// at once; on a histogram last pixel the block scans 256 bins, builds the table with a
// bit-serial divider (used for each entry above lo and at or below hi, a fixed value
// for the others), then clears the bins, stalling input throughout. After reset a sweep
// clears the bin memory while input stalls. A map pixel (kind 1) can follow another at
// once, limited by the table read port, until downstream stall fills the pipe; its
// result passes through the table read register and then the output register.
// top level: uses hcs_pkg, hcs_ctrl, hcs_datapath

module histogram_contrast_stretch_unit
    import hcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int BINS       = BINS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_item                 i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_item                o_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [COUNT_BITS-1:0] r_min_count;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;
    logic    w_acc;
    logic    w_hist;
    logic    w_map;
    logic    r_init;
    logic [PIX_BITS-1:0] r_init_cnt;
    logic    r_p1_vld;
    logic    r_p1_last;
    logic    r_out_vld;
    t_out_item r_out;
    logic [PIX_BITS-1:0] w_map_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= '0;
        end else if (psel && penable && pwrite && paddr == ADDR_MIN_COUNT) begin
            r_min_count <= pwdata[COUNT_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MIN_COUNT) begin
            prdata[COUNT_BITS-1:0] = r_min_count;
        end
    end

    // stall while busy, during the reset sweep, or while both pipe stages hold results and downstream stalls
    assign o_stall = w_busy || r_init || (r_out_vld && i_stall && r_p1_vld);
    assign w_acc   = i_valid && !o_stall;
    assign w_hist  = w_acc && i_data.kind == KIND_HIST;
    assign w_map   = w_acc && i_data.kind == KIND_MAP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_cnt <= '0;
            r_p1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_init) begin
                r_init_cnt <= r_init_cnt + 1'b1;
                if (&r_init_cnt) begin
                    r_init <= 1'b0;
                end
            end
            if (r_p1_vld && (!r_out_vld || !i_stall)) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_map) begin
                r_p1_vld <= 1'b1;
            end else if (!r_out_vld || !i_stall) begin
                r_p1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map) begin
            r_p1_last <= i_data.last;
        end
        if (r_p1_vld && (!r_out_vld || !i_stall)) begin
            r_out.mapped_pixel <= w_map_data;
            r_out.out_last     <= r_p1_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    hcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hist && i_data.last),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    hcs_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .BINS       (BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_min_count (r_min_count),
        .i_hist_en   (w_hist),
        .i_hist_pix  (i_data.pixel),
        .i_map_rd    (w_map),
        .i_map_pix   (i_data.pixel),
        .o_map_data  (w_map_data)
    );

endmodule
